// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL of the gated feedback delay.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define ASSERT_IMPLIES(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("gated feedback delay: assertion failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("gated feedback delay: assertion failed");

`endif

// File: hw/rtl/gfd_pkg.sv
// Package of the gated feedback delay: defaults, register map and fixed widths.
`timescale 1ns / 1ps
`default_nettype none

package gfd_pkg;

	localparam int DEF_MAX_DELAY_SAMPLES = 262144;
	localparam int DEF_CHANNELS          = 2;
	localparam int DEF_SAMPLE_BITS       = 24;

	localparam int DELAY_W    = 18;
	localparam int GAIN_W     = 17;
	localparam int GAIN_FRAC  = 16;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 18;

	localparam int DELAY_RST = 24000;
	localparam logic [GAIN_W-1:0] GAIN_RST   = 17'd32768;
	localparam logic [GAIN_W-1:0] UNITY_GAIN = 17'd65536;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DELAY_LENGTH  = 1'b0,
		REG_FEEDBACK_GAIN = 1'b1
	} cfg_reg_t;

endpackage

`default_nettype wire

// File: hw/rtl/gfd_ifs.sv
// Valid/ready channel interfaces of the gated feedback delay.
`timescale 1ns / 1ps
`default_nettype none

interface gfd_feed_if import gfd_pkg::*; #(
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
	parameter int CHANNELS    = DEF_CHANNELS
) ();
	localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_in;
	logic [CH_W-1:0]               channel;
	logic                          gate;

	modport source (output valid, sample_in, channel, gate, input ready);
	modport sink   (input valid, sample_in, channel, gate, output ready);
endinterface

interface gfd_mix_if import gfd_pkg::*; #(
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) ();
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_out;

	modport source (output valid, sample_out, input ready);
	modport sink   (input valid, sample_out, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/gated_feedback_delay.sv
// Gated stereo feedback echo: two-stage datapath over a per-channel ring memory.
//
// Usage:
//   feed : input transfers of sample_in, channel and gate (valid/ready).
//   mix  : one output transfer of sample_out per input transfer, in order.
//   cfg  : cfg_we/cfg_index/cfg_data write delay_length (0) or feedback_gain (1);
//          write only while no transfer is in flight.
// Path: an accepted input is registered in stage 1 and then in stage 2, which
//   is the output register that offers the result on mix.
// Throughput: one transfer per cycle while mix.ready is high; an echo item reads
//   the ring when accepted and writes it when its result leaves, on separate ports.
// Gate low (or a channel without a ring): sample passes through, ring and
//   pointers untouched.
// Reset: pointers clear, delay_length = 24000, feedback_gain = 32768. The ring
//   is not swept; per-channel wrap flags make never-written entries read zero,
//   so transfers are taken as soon as reset is released.
// Stall: the output register holds while mix.ready is low; feed.ready stays
//   high while the first stage is empty, so one more transfer is taken.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module gated_feedback_delay import gfd_pkg::*; #(
	parameter int MAX_DELAY_SAMPLES = DEF_MAX_DELAY_SAMPLES,
	parameter int CHANNELS          = DEF_CHANNELS,
	parameter int SAMPLE_BITS       = DEF_SAMPLE_BITS
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	gfd_feed_if.sink                   feed,
	gfd_mix_if.source                  mix
);

	localparam int AW   = $clog2(MAX_DELAY_SAMPLES);
	localparam int DW   = AW + 1;
	localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int CMPW = (DELAY_W > DW) ? DELAY_W : DW;
	localparam int SB   = SAMPLE_BITS;
	localparam int PW   = SB + GAIN_W + 1;
	localparam int RW   = PW - GAIN_FRAC;

	localparam logic [DW-1:0] DELAY_MAX  = DW'(MAX_DELAY_SAMPLES);
	localparam logic [DW-1:0] DELAY_INIT = (DELAY_RST > MAX_DELAY_SAMPLES) ?
		DW'(MAX_DELAY_SAMPLES) : DW'(DELAY_RST);
	localparam logic [CH_W:0] CH_LIMIT = (CH_W + 1)'(CHANNELS);
	localparam logic signed [PW-1:0] RND_HALF = PW'(1) <<< (GAIN_FRAC - 1);
	localparam logic signed [SB-1:0] SAT_HI = {1'b0, {(SB - 1){1'b1}}};
	localparam logic signed [SB-1:0] SAT_LO = {1'b1, {(SB - 1){1'b0}}};

	function automatic logic signed [SB-1:0] sat_sb(input logic signed [SB+1:0] v);
		if (v > (SB + 2)'(SAT_HI))
			return SAT_HI;
		else if (v < (SB + 2)'(SAT_LO))
			return SAT_LO;
		else
			return v[SB-1:0];
	endfunction

	// configuration
	logic [DW-1:0]     delay_q;
	logic [GAIN_W-1:0] gain_q;
	logic [CMPW-1:0]   dly_raw;
	logic [DW-1:0]     dly_clamp;
	logic [GAIN_W-1:0] gain_raw;
	logic [GAIN_W-1:0] gain_clamp;

	always_comb begin
		dly_raw  = CMPW'(cfg_data[DELAY_W-1:0]);
		gain_raw = cfg_data[GAIN_W-1:0];
		if (dly_raw == '0) begin
			dly_clamp = DW'(1);
		end else if (dly_raw > CMPW'(MAX_DELAY_SAMPLES)) begin
			dly_clamp = DELAY_MAX;
		end else begin
			dly_clamp = DW'(dly_raw);
		end
		gain_clamp = (gain_raw > UNITY_GAIN) ? UNITY_GAIN : gain_raw;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q <= DELAY_INIT;
			gain_q  <= GAIN_RST;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_DELAY_LENGTH:  delay_q <= dly_clamp;
				REG_FEEDBACK_GAIN: gain_q  <= gain_clamp;
				default: ;
			endcase
		end
	end

	// pipeline control
	logic v_s1, v_s2;
	logic s1_adv, s2_adv, s2_free, acc;

	assign s2_free    = !v_s2 || mix.ready;
	assign s2_adv     = v_s2 && mix.ready;
	assign s1_adv     = v_s1 && s2_free;
	assign feed.ready = !v_s1 || s2_free;
	assign acc        = feed.valid && feed.ready;

	// write pointers and wrap flags
	logic [AW-1:0]       wp_q [CHANNELS];
	logic [CHANNELS-1:0] full_q;
	logic [AW-1:0]       wp_cur, rd_in, wp_inc;
	logic [DW-1:0]       wp_x;
	logic                echo_in, back, wrap, hit_in;

	always_comb begin
		echo_in = feed.gate && ({1'b0, feed.channel} < CH_LIMIT);
		wp_cur  = wp_q[feed.channel];
		wp_x    = {1'b0, wp_cur};
		back    = wp_x >= delay_q;
		if (back) begin
			rd_in = AW'(wp_x - delay_q);
		end else begin
			rd_in = AW'(wp_x + DELAY_MAX - delay_q);
		end
		hit_in = full_q[feed.channel] || back;
		wrap   = (wp_x + DW'(1)) == DELAY_MAX;
		wp_inc = wrap ? '0 : AW'(wp_x + DW'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				wp_q[i] <= '0;
			end
			full_q <= '0;
		end else if (acc && echo_in) begin
			wp_q[feed.channel] <= wp_inc;
			if (wrap) begin
				full_q[feed.channel] <= 1'b1;
			end
		end
	end

	// ring memory
	logic signed [SB-1:0] ring_mem [CHANNELS * (2 ** AW)];
	logic signed [SB-1:0] rdata_s1;
	logic signed [SB-1:0] wdata_s2;
	logic [CH_W+AW-1:0]   raddr, waddr;
	logic                 mem_re, mem_we;

	logic                 echo_s1, hit_s1;
	logic [CH_W-1:0]      ch_s1;
	logic [AW-1:0]        wp_s1, rd_s1;
	logic signed [SB-1:0] x_s1;

	logic                 echo_s2;
	logic [CH_W-1:0]      ch_s2;
	logic [AW-1:0]        wp_s2;
	logic signed [SB-1:0] x_s2;
	logic signed [PW-1:0] prod_s2;
	logic signed [SB-1:0] out_s2;

	assign raddr  = {feed.channel, rd_in};
	assign waddr  = {ch_s2, wp_s2};
	assign mem_re = acc && echo_in;
	assign mem_we = s2_adv && echo_s2;

	// write-first on a same-edge address match
	always_ff @(posedge clk) begin
		if (mem_we) begin
			ring_mem[waddr] <= wdata_s2;
		end
		if (mem_re) begin
			rdata_s1 <= (mem_we && waddr == raddr) ? wdata_s2 : ring_mem[raddr];
		end
	end

	// stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (acc) begin
			v_s1 <= 1'b1;
		end else if (s1_adv) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			echo_s1 <= echo_in;
			hit_s1  <= hit_in;
			ch_s1   <= feed.channel;
			wp_s1   <= wp_cur;
			rd_s1   <= rd_in;
			x_s1    <= feed.sample_in;
		end
	end

	logic                 fwd_s1;
	logic signed [SB-1:0] delayed_s1;
	logic signed [PW-1:0] prod_s1;
	logic signed [SB-1:0] out_s1;

	// forward from the older item still waiting in stage 2
	always_comb begin
		fwd_s1 = v_s2 && echo_s2 && (ch_s2 == ch_s1) && (wp_s2 == rd_s1);
		if (fwd_s1) begin
			delayed_s1 = wdata_s2;
		end else if (hit_s1) begin
			delayed_s1 = rdata_s1;
		end else begin
			delayed_s1 = '0;
		end
		prod_s1 = delayed_s1 * $signed({1'b0, gain_q});
		if (echo_s1) begin
			out_s1 = sat_sb((SB + 2)'(x_s1) + (SB + 2)'(delayed_s1));
		end else begin
			out_s1 = x_s1;
		end
	end

	// stage 2, also the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (s1_adv) begin
			v_s2 <= 1'b1;
		end else if (s2_adv) begin
			v_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			echo_s2 <= echo_s1;
			ch_s2   <= ch_s1;
			wp_s2   <= wp_s1;
			x_s2    <= x_s1;
			prod_s2 <= prod_s1;
			out_s2  <= out_s1;
		end
	end

	logic signed [PW-1:0] rnd_s2;
	logic signed [RW-1:0] fb_s2;

	// round half up, then saturate the ring sample
	always_comb begin
		rnd_s2   = prod_s2 + RND_HALF;
		fb_s2    = rnd_s2[PW-1:GAIN_FRAC];
		wdata_s2 = sat_sb((SB + 2)'(x_s2) + (SB + 2)'(fb_s2));
	end

	assign mix.valid      = v_s2;
	assign mix.sample_out = out_s2;

	`ASSERT_IMPLIES(a_ready_when_s1_empty, !v_s1, feed.ready)
	`ASSERT_NEXT(a_s1_moves_to_s2, s1_adv, v_s2)
	`ASSERT_IMPLIES(a_delay_range, 1'b1, delay_q != '0 && delay_q <= DELAY_MAX)
	`ASSERT_IMPLIES(a_write_in_ring, mem_we, wp_s2 <= AW'(MAX_DELAY_SAMPLES - 1))

endmodule

`default_nettype wire
